### design/segregated_pool_allocator_assert.svh
// Assertion macros shared by the segregated pool allocator RTL.
`ifndef SEGREGATED_POOL_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_POOL_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define SPA_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("segregated pool allocator: assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define SPA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("segregated pool allocator: assertion failed");
`else
`define SPA_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define SPA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

### design/spa_pkg.sv
// Shared types, constants and the size-class function of the pool allocator.
package spa_pkg;

    // Fixed geometry
    localparam int CHUNK_SHIFT  = 12;
    localparam int MIN_SHIFT    = 5;
    localparam int CLASS_W      = 3;
    localparam int CLASS_COUNT  = 8;
    localparam int ADDR_OUT_W   = 18;
    localparam int HDR_BYTES    = 8;
    localparam int MAX_POOL_REQ = 4088;

    typedef logic [1:0] status_t;

    // Result status codes
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_IGNORE  = 2'd1;
    localparam status_t ST_BULK    = 2'd2;
    localparam status_t ST_EXHAUST = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic pop_fin;
        logic free_fin;
    } spa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic eval_done;
        logic eval_pop;
    } spa_sts_t;

    // Class number from size+7 (12 bits): bit length minus 5, floor 0
    function automatic logic [CLASS_W-1:0] size_class(input logic [11:0] v);
        logic [CLASS_W-1:0] c;
        if (v[11])      c = 3'd7;
        else if (v[10]) c = 3'd6;
        else if (v[9])  c = 3'd5;
        else if (v[8])  c = 3'd4;
        else if (v[7])  c = 3'd3;
        else if (v[6])  c = 3'd2;
        else if (v[5])  c = 3'd1;
        else            c = 3'd0;
        return c;
    endfunction

endpackage

### design/spa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/spa_ctrl.sv
// Request sequencer of the pool allocator: accept, evaluate, finish.
`include "segregated_pool_allocator_assert.svh"

module spa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  spa_pkg::spa_sts_t sts,
    output spa_pkg::spa_cmd_t cmd,
    output logic              busy
);
    import spa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_FREE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.eval_done)
                    state_next = S_IDLE;
                else if (sts.eval_pop)
                    state_next = S_POP;
                else
                    state_next = S_FREE;
            end
            S_POP:
            begin
                cmd.pop_fin = 1'b1;
                state_next  = S_IDLE;
            end
            S_FREE:
            begin
                cmd.free_fin = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    `SPA_ASSERT_NEXT(a_accept_to_eval, clk, rst_n, start && !busy, state_reg == S_EVAL)
    `SPA_ASSERT_NEXT(a_finish_to_idle, clk, rst_n, state_reg == S_POP || state_reg == S_FREE, state_reg == S_IDLE)
    `SPA_ASSERT_IMPL(a_eval_after_idle, clk, rst_n, state_reg == S_EVAL, $past(state_reg) == S_IDLE)

endmodule

### design/spa_dp.sv
// Allocator datapath: class heads, carve pointers, chunk count, link and class memories.
`include "segregated_pool_allocator_assert.svh"

module spa_dp #(
    parameter int POOL_CHUNKS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spa_pkg::spa_cmd_t                   cmd,
    output spa_pkg::spa_sts_t                   sts,
    input  logic                                req_type,
    input  logic [31:0]                         req_size,
    input  logic [31:0]                         addr,
    output logic                                done,
    output logic [spa_pkg::ADDR_OUT_W-1:0]      block_addr,
    output spa_pkg::status_t                    status
);
    import spa_pkg::*;

    localparam int CW    = (POOL_CHUNKS > 1) ? $clog2(POOL_CHUNKS) : 1;
    localparam int UW    = $clog2(POOL_CHUNKS + 1);
    localparam int AW    = CW + CHUNK_SHIFT;
    localparam int SW    = CW + CHUNK_SHIFT - MIN_SHIFT;
    localparam int LW    = SW + 1;
    localparam int SLOTS = POOL_CHUNKS << (CHUNK_SHIFT - MIN_SHIFT);

    // Latched request
    logic        type_reg;
    logic [31:0] size_reg;
    logic [31:0] addr_reg;

    // Allocator state: head entries are {valid, slot index}
    logic [LW-1:0]  head_reg       [CLASS_COUNT];
    logic           carve_vld_reg  [CLASS_COUNT];
    logic [AW-1:0]  carve_base_reg [CLASS_COUNT];
    logic [UW-1:0]  chunks_used_reg;

    // Result registers
    logic                  done_reg;
    logic                  done_next;
    logic [ADDR_OUT_W-1:0] addr_out_reg;
    logic [ADDR_OUT_W-1:0] addr_out_next;
    status_t               status_reg;
    status_t               status_next;

    // Decode signals
    logic [11:0]        size_v;
    logic [CLASS_W-1:0] cls;
    logic [CLASS_W-1:0] fr_cls;
    logic [CLASS_W-1:0] head_sel;
    logic [LW-1:0]      head_rd;
    logic               size_zero;
    logic               size_big;
    logic               pop_hit;
    logic               fresh_chunk;
    logic               exhausted;
    logic [AW-1:0]      carve_base;
    logic [AW-1:0]      bsize;
    logic [AW-1:0]      carve_nxt;
    logic               carve_go;
    logic [31:0]        off;
    logic               outside;
    logic [SW-1:0]      slot_mask;
    logic [SW-1:0]      fr_idx;
    logic [31:0]        pop_addr_full;
    logic [31:0]        carve_addr_full;
    logic [LW-1:0]      link_rdata;
    logic [CLASS_W-1:0] chunk_rdata;

    // Request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg <= req_type;
            size_reg <= req_size;
            addr_reg <= addr;
        end
    end

    // Size class, list head and carve decode
    always_comb
    begin
        size_v      = size_reg[11:0] + 12'd7;
        cls         = size_class(size_v);
        fr_cls      = chunk_rdata;
        head_sel    = cmd.free_fin ? fr_cls : cls;
        head_rd     = head_reg[head_sel];
        size_zero   = (size_reg == 32'd0);
        size_big    = (size_reg > 32'(MAX_POOL_REQ));
        pop_hit     = head_rd[LW-1];
        fresh_chunk = !carve_vld_reg[cls];
        exhausted   = fresh_chunk && (chunks_used_reg >= UW'(POOL_CHUNKS));
        carve_base  = carve_vld_reg[cls] ? carve_base_reg[cls]
                                         : {chunks_used_reg[CW-1:0], {CHUNK_SHIFT{1'b0}}};
        bsize       = AW'(1 << MIN_SHIFT) << cls;
        carve_nxt   = carve_base + bsize;
    end

    // Free address checks and block slot
    always_comb
    begin
        off       = addr_reg - 32'(HDR_BYTES);
        outside   = (addr_reg < 32'(HDR_BYTES)) ||
                    (off >= 32'({chunks_used_reg, {CHUNK_SHIFT{1'b0}}}));
        slot_mask = ~((SW'(1) << fr_cls) - SW'(1));
        fr_idx    = off[AW-1:MIN_SHIFT] & slot_mask;
    end

    // Evaluate-cycle outcome
    always_comb
    begin
        sts.eval_done = 1'b1;
        sts.eval_pop  = 1'b0;
        carve_go      = 1'b0;
        if (!type_reg)
        begin
            if (!size_zero && !size_big && pop_hit)
            begin
                sts.eval_done = 1'b0;
                sts.eval_pop  = 1'b1;
            end
            else if (!size_zero && !size_big && !exhausted)
            begin
                carve_go = cmd.eval;
            end
        end
        else if (addr_reg != 32'd0 && !outside)
        begin
            sts.eval_done = 1'b0;
        end
    end

    // Result values
    always_comb
    begin
        pop_addr_full   = 32'({head_rd[SW-1:0], {MIN_SHIFT{1'b0}}}) + 32'(HDR_BYTES);
        carve_addr_full = 32'(carve_base) + 32'(HDR_BYTES);
        done_next       = 1'b0;
        addr_out_next   = '0;
        status_next     = ST_OK;
        if (cmd.eval && sts.eval_done)
        begin
            done_next = 1'b1;
            if (!type_reg)
            begin
                if (size_zero)
                    status_next = ST_IGNORE;
                else if (size_big)
                    status_next = ST_BULK;
                else if (exhausted)
                    status_next = ST_EXHAUST;
                else
                    addr_out_next = carve_addr_full[ADDR_OUT_W-1:0];
            end
            else if (addr_reg == 32'd0)
                status_next = ST_IGNORE;
            else
                status_next = ST_BULK;
        end
        else if (cmd.pop_fin)
        begin
            done_next     = 1'b1;
            addr_out_next = pop_addr_full[ADDR_OUT_W-1:0];
        end
        else if (cmd.free_fin)
        begin
            done_next = 1'b1;
        end
    end

    // Heads, carve pointers and chunk count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                head_reg[i]       <= '0;
                carve_vld_reg[i]  <= 1'b0;
                carve_base_reg[i] <= '0;
            end
            chunks_used_reg <= '0;
        end
        else
        begin
            if (cmd.pop_fin)
                head_reg[cls] <= link_rdata;
            else if (cmd.free_fin)
                head_reg[fr_cls] <= {1'b1, fr_idx};
            if (carve_go)
            begin
                carve_vld_reg[cls]  <= (carve_nxt[CHUNK_SHIFT-1:0] != '0);
                carve_base_reg[cls] <= carve_nxt;
                if (fresh_chunk)
                    chunks_used_reg <= chunks_used_reg + UW'(1);
            end
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        addr_out_reg <= addr_out_next;
        status_reg   <= status_next;
    end

    // Next-link memory, one entry per 32-byte slot
    spa_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (cmd.free_fin),
        .waddr (fr_idx),
        .wdata (head_rd),
        .raddr (head_rd[SW-1:0]),
        .rdata (link_rdata)
    );

    // Class of each claimed chunk
    spa_ram #(
        .WIDTH (CLASS_W),
        .DEPTH (POOL_CHUNKS)
    ) u_chunk_ram (
        .clk   (clk),
        .we    (carve_go && fresh_chunk),
        .waddr (chunks_used_reg[CW-1:0]),
        .wdata (cls),
        .raddr (off[AW-1:CHUNK_SHIFT]),
        .rdata (chunk_rdata)
    );

    assign done       = done_reg;
    assign block_addr = addr_out_reg;
    assign status     = status_reg;

    `SPA_ASSERT_IMPL(a_fail_zero_addr, clk, rst_n, done_reg && status_reg != ST_OK, addr_out_reg == '0)
    `SPA_ASSERT_IMPL(a_chunks_bound, clk, rst_n, 1'b1, chunks_used_reg <= UW'(POOL_CHUNKS))

endmodule

### design/segregated_pool_allocator.sv
// Top level of the segregated power-of-two pool allocator.
//
//   channel   | handshake            | fields
//   ----------+----------------------+-------------------------------
//   request   | start, busy          | req_type, req_size, addr
//   result    | done (one-cycle)     | block_addr, status
//
// A request is taken when start is high and busy is low; done is registered from the
// evaluate state, or from the pop or free finish state for an allocate served from a free
// list and for a pool free, which wait on the link or chunk-class memory read.
// busy is low in the done cycle, so the next request can be taken there.
// Reset leaves every free list empty and no chunk claimed; no clearing pass runs.
// The result strobe cannot be held off by the receiver.
module segregated_pool_allocator #(
    parameter int POOL_CHUNKS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           req_type,
    input  logic [31:0]                    req_size,
    input  logic [31:0]                    addr,
    output logic                           done,
    output logic [spa_pkg::ADDR_OUT_W-1:0] block_addr,
    output spa_pkg::status_t               status
);
    import spa_pkg::*;

    spa_cmd_t cmd;
    spa_sts_t sts;

    // Sequencer
    spa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Datapath
    spa_dp #(
        .POOL_CHUNKS (POOL_CHUNKS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_type   (req_type),
        .req_size   (req_size),
        .addr       (addr),
        .done       (done),
        .block_addr (block_addr),
        .status     (status)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for the segregated power-of-two pool allocator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spa_pkg::*;

    localparam int POOL_CHUNKS = 64;
    localparam int SLOTS       = POOL_CHUNKS * (1 << CHUNK_SHIFT) / (1 << MIN_SHIFT);
    localparam int LIMIT       = 200000;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 95;
    localparam int HEAVY_PHASE = 2;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct {
        logic        kind;
        logic [31:0] size;
        logic [31:0] a;
    } request_t;

    typedef struct {
        logic [ADDR_OUT_W-1:0] blk;
        status_t               st;
    } answer_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  req_type = 1'b0;
    logic [31:0]           req_size = '0;
    logic [31:0]           addr = '0;
    logic                  busy;
    logic                  done;
    logic [ADDR_OUT_W-1:0] block_addr;
    status_t               status;

    segregated_pool_allocator #(.POOL_CHUNKS(POOL_CHUNKS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .req_size   (req_size),
        .addr       (addr),
        .done       (done),
        .block_addr (block_addr),
        .status     (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Allocator shadow state
    logic [13:0]          pool_head [CLASS_COUNT];
    logic [13:0]          next_link [SLOTS];
    logic [18:0]          carve_ptr [CLASS_COUNT];
    logic [CLASS_W-1:0]   chunk_cls [POOL_CHUNKS];
    int unsigned          chunk_count = 0;

    request_t    request_q [$];
    answer_t     answer_q [$];
    logic [31:0] held_blocks [$];

    logic        took = 1'b0;
    int          idle_pct = 0;
    int          issued_cnt = 0;
    int          taken_cnt = 0;
    int          fail_cnt = 0;
    int          free_cnt = 0;
    int          status_tally [4] = '{0, 0, 0, 0};
    int          cycles = 0;
    int          phase_idle [PHASES] = '{0, 71, 28, 0, 71};

    initial
    begin
        for (int i = 0; i < CLASS_COUNT; i++)
        begin
            pool_head[i] = '0;
            carve_ptr[i] = '0;
        end
    end

    // Class number: bit length of size+7, minus 5
    function automatic logic [CLASS_W-1:0] class_of(input logic [31:0] size);
        logic [12:0] v;
        int          len;
        v = size[12:0] + 13'd7;
        len = MIN_SHIFT;
        while (len < 13 && (v >> len) != 0)
            len++;
        return CLASS_W'(len - MIN_SHIFT);
    endfunction

    // Expected answer for one request; updates the shadow state
    function automatic answer_t serve_request(input request_t r);
        answer_t            res;
        logic [CLASS_W-1:0] c;
        logic [31:0]        bsize, base, nxt, limit;
        logic [12:0]        idx;
        res.blk = '0;
        res.st  = ST_OK;
        if (r.kind == REQ_ALLOC)
        begin
            if (r.size == 0)
                res.st = ST_IGNORE;
            else if (r.size > MAX_POOL_REQ)
                res.st = ST_BULK;
            else
            begin
                c = class_of(r.size);
                bsize = 32'd32 << c;
                if (pool_head[c] != 0)
                begin
                    // pop the class free list
                    idx = 13'(pool_head[c] - 14'd1);
                    pool_head[c] = next_link[idx];
                    res.blk = ADDR_OUT_W'({idx, 5'd0}) + ADDR_OUT_W'(HDR_BYTES);
                end
                else if (carve_ptr[c] == 0 && chunk_count >= POOL_CHUNKS)
                    res.st = ST_EXHAUST;
                else
                begin
                    if (carve_ptr[c] != 0)
                        base = 32'(carve_ptr[c]) - 32'd1;
                    else
                    begin
                        // claim a fresh chunk for this class
                        base = chunk_count << CHUNK_SHIFT;
                        chunk_cls[chunk_count] = c;
                        chunk_count++;
                    end
                    nxt = base + bsize;
                    carve_ptr[c] = (nxt[11:0] == 0) ? '0 : 19'(nxt + 32'd1);
                    res.blk = ADDR_OUT_W'(base + HDR_BYTES);
                end
            end
        end
        else
        begin
            limit = chunk_count << CHUNK_SHIFT;
            if (r.a == 0)
                res.st = ST_IGNORE;
            else if (r.a < HDR_BYTES || r.a - HDR_BYTES >= limit)
                res.st = ST_BULK;
            else
            begin
                // round down to the block boundary, push onto the class list
                base = r.a - HDR_BYTES;
                c = chunk_cls[base[17:12]];
                bsize = 32'd32 << c;
                base = base & ~(bsize - 32'd1);
                idx = base[17:5];
                next_link[idx] = pool_head[c];
                pool_head[c] = {1'b0, idx} + 14'd1;
            end
        end
        return res;
    endfunction

    // Driver: new request at the falling edge once the last one was taken
    always @(negedge clk)
    begin
        request_t r;
        if (rst_n && (!start || took))
        begin
            if (request_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                r = request_q.pop_front();
                start    <= 1'b1;
                req_type <= r.kind;
                req_size <= r.size;
                addr     <= r.a;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check strobed results, predict accepted requests
    always @(posedge clk)
    begin
        answer_t  want;
        request_t r;
        if (rst_n)
        begin
            if (done)
            begin
                if (answer_q.size() == 0)
                begin
                    fail_cnt++;
                    $display("%0t: result with none expected: block_addr %0d status %0d",
                             $time, block_addr, status);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (block_addr !== want.blk)
                    begin
                        fail_cnt++;
                        $display("%0t: block_addr expected %0d, got %0d",
                                 $time, want.blk, block_addr);
                    end
                    if (status !== want.st)
                    begin
                        fail_cnt++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.st, status);
                    end
                end
            end
            if (start && !busy)
            begin
                r.kind = req_type;
                r.size = req_size;
                r.a    = addr;
                want = serve_request(r);
                answer_q.push_back(want);
                taken_cnt++;
                status_tally[want.st]++;
                if (r.kind == REQ_FREE)
                    free_cnt++;
                else if (want.st == ST_OK)
                    held_blocks.push_back(32'(want.blk));
                took <= 1'b1;
            end
            else
                took <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycles, answer_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Quiet slot just after the falling edge
    task automatic next_slot();
        @(negedge clk);
        #1;
    endtask

    task automatic push_request(input logic kind, input logic [31:0] size,
                                input logic [31:0] a);
        request_t r;
        while (request_q.size() >= 4)
            next_slot();
        r.kind = kind;
        r.size = size;
        r.a    = a;
        request_q.push_back(r);
        issued_cnt++;
    endtask

    task automatic wait_drained();
        while (taken_cnt != issued_cnt || answer_q.size() != 0)
            next_slot();
    endtask

    // Random size that lands in class k
    function automatic logic [31:0] size_in_class(input int k);
        int lo, hi;
        hi = (32 << k) - 8;
        lo = (k == 0) ? 1 : (16 << k) - 7;
        return 32'($urandom_range(hi, lo));
    endfunction

    // One random request; heavy mode leans on large allocations
    task automatic random_request(input bit heavy);
        int          roll, k, i;
        logic [31:0] a;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            // malformed or edge requests
            case ($urandom_range(5))
                0: push_request(REQ_ALLOC, 32'd0, $urandom);
                1: push_request(REQ_ALLOC, $urandom, $urandom);
                2: push_request(REQ_FREE, $urandom, 32'd0);
                3: push_request(REQ_FREE, $urandom, 32'($urandom_range(7, 1)));
                4: push_request(REQ_FREE, $urandom, $urandom);
                default: push_request(REQ_FREE, $urandom,
                                      (chunk_count << CHUNK_SHIFT) + 32'd8 +
                                      32'($urandom_range(8191)));
            endcase
        end
        else if (roll < (heavy ? 88 : 55) || held_blocks.size() == 0)
        begin
            if (heavy && $urandom_range(99) < 75)
                k = CLASS_COUNT - 1;
            else
                k = $urandom_range(CLASS_COUNT - 1);
            push_request(REQ_ALLOC, size_in_class(k), $urandom);
        end
        else
        begin
            // free a block handed out earlier; sometimes keep it for a double free
            i = $urandom_range(held_blocks.size() - 1);
            a = held_blocks[i];
            if ($urandom_range(9) != 0)
                held_blocks.delete(i);
            if ($urandom_range(3) == 0)
                a += 32'($urandom_range(23, 1));
            push_request(REQ_FREE, $urandom, a);
        end
    endtask

    // Stimulus
    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        next_slot();

        // directed: size boundaries, every class, bulk, null, outside and odd frees
        push_request(REQ_ALLOC, 32'd0, 32'd0);
        push_request(REQ_ALLOC, 32'd1, 32'd0);
        push_request(REQ_ALLOC, 32'd24, 32'd0);
        push_request(REQ_ALLOC, 32'd25, 32'd0);
        push_request(REQ_ALLOC, 32'd4088, 32'd0);
        push_request(REQ_ALLOC, 32'd4089, 32'd0);
        push_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(REQ_ALLOC, 32'd57, 32'd0);
        push_request(REQ_ALLOC, 32'd121, 32'd0);
        push_request(REQ_ALLOC, 32'd249, 32'd0);
        push_request(REQ_ALLOC, 32'd505, 32'd0);
        push_request(REQ_ALLOC, 32'd1017, 32'd0);
        push_request(REQ_ALLOC, 32'd2040, 32'd0);
        push_request(REQ_FREE, 32'd0, 32'd0);
        push_request(REQ_FREE, 32'd0, 32'd7);
        push_request(REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(REQ_FREE, 32'd0, 32'h0004_0000);
        push_request(REQ_FREE, 32'd0, 32'd8);
        push_request(REQ_FREE, 32'd0, 32'd21);      // misaligned, same block again
        push_request(REQ_ALLOC, 32'd1, 32'd0);
        push_request(REQ_ALLOC, 32'd16, 32'd0);     // same block handed out twice
        push_request(REQ_FREE, 32'd0, 32'd8300);    // inside a 4096-byte block
        push_request(REQ_ALLOC, 32'd4000, 32'd0);
        push_request(REQ_FREE, 32'd0, 32'd4144);    // rounds down in a 64-byte block
        wait_drained();

        // random phases; the sender pauses for every result between them
        for (int p = 0; p < PHASES; p++)
        begin
            idle_pct = phase_idle[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_request(p == HEAVY_PHASE);
            wait_drained();
        end

        idle_pct = 0;
        repeat (8) @(posedge clk);
        $display("%0d requests: %0d ok, %0d ignored, %0d to bulk, %0d exhausted (%0d frees)",
                 taken_cnt, status_tally[ST_OK], status_tally[ST_IGNORE],
                 status_tally[ST_BULK], status_tally[ST_EXHAUST], free_cnt);
        $display("%0d of %0d chunks claimed, %0d mismatches",
                 chunk_count, POOL_CHUNKS, fail_cnt);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### segregated_pool_allocator.f
+incdir+design
design/spa_pkg.sv
design/spa_ram.sv
design/spa_ctrl.sv
design/spa_dp.sv
design/segregated_pool_allocator.sv
tb/tb.sv
